// ===== design/pixel_click_to_view_angle_macros.svh =====
// Assertion macros for the pixel click to view angle block.
`ifndef PIXEL_CLICK_TO_VIEW_ANGLE_MACROS_SVH
`define PIXEL_CLICK_TO_VIEW_ANGLE_MACROS_SVH

// next-cycle implication, disabled during reset
`define PCTVA_ASSERT_NEXT(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ant) |=> (con)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define PCTVA_ASSERT_NEXT_RST(lbl, ant, con, msg) \
   lbl: assert property (@(posedge clock) (ant) |=> (con)) else $error(msg);

`endif

// ===== design/pctva_pkg.sv =====
// Shared constants, types and the arctangent table of the view angle block.
package pctva_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int COORD_BITS   = 13;
   localparam int FOV_BITS     = 15;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 15;
   localparam int OUT_BITS     = 18;

   localparam int DIV_BITS = 18;
   localparam int D_W      = COORD_BITS + 18;
   localparam int KW       = 32;
   localparam int CW       = 52;
   localparam int ZW       = 33;
   localparam int NW       = DIV_BITS + 1;
   localparam int MAG_W    = 51;
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = 2;

   localparam logic [DIV_BITS-1:0] Q_SAT = DIV_BITS'(131072);

   localparam logic [CSR_IDX_BITS-1:0] CSR_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HFOV   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_VFOV   = 3'd3;

   localparam int AX_AZ = 0;
   localparam int AX_EL = 1;

   typedef struct packed {
      logic [D_W-1:0] d;
      logic           neg;
   } axis_type;

   typedef struct packed {
      axis_type [1:0] ax;
   } item_type;

   typedef struct packed {
      logic [1:0][COORD_BITS-1:0] size;
      logic [1:0][KW-1:0]         kcos;
      logic [1:0][KW-1:0]         ksin;
      logic                       busy;
   } cfg_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2FA;
         5'd15: v = 32'h0000517D;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A30;
         5'd19: v = 32'h00000518;
         5'd20: v = 32'h0000028C;
         5'd21: v = 32'h00000146;
         5'd22: v = 32'h000000A3;
         5'd23: v = 32'h00000051;
         5'd24: v = 32'h00000029;
         5'd25: v = 32'h00000014;
         5'd26: v = 32'h0000000A;
         5'd27: v = 32'h00000005;
         5'd28: v = 32'h00000003;
         5'd29: v = 32'h00000001;
         5'd30: v = 32'h00000001;
         5'd31: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage

// ===== design/pixel_click_to_view_angle.sv =====
// From request accept to result, a request passes the 18-stage divider, tangent multiply,
// CORDIC_STEPS vectoring stages and scaling. Throughput: one request per cycle unless an
// unpopped result stalls the back end; a 4-entry queue splits front and back ends.
// Reset (synchronous): registers take defaults, queues empty, then the field-of-view
// precompute runs with req_full high; any csr write reruns it.
module pixel_click_to_view_angle
   import pctva_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [COORD_BITS-1:0]      req_click_x,
   input  logic [COORD_BITS-1:0]      req_click_y,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [OUT_BITS-1:0] rsp_delta_az,
   output logic signed [OUT_BITS-1:0] rsp_delta_el,
   input  logic                       csr_we,
   input  logic [CSR_IDX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   cfg_type  cfg;
   item_type head;
   logic     head_valid, take;

   pctva_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pctva_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .click_x    (req_click_x),
      .click_y    (req_click_y),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .take       (take)
   );

   pctva_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head       (head),
      .head_valid (head_valid),
      .take       (take),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .delta_az   (rsp_delta_az),
      .delta_el   (rsp_delta_el)
   );

endmodule

// ===== design/pctva_setup.sv =====
// Register file and field-of-view precompute: half angle by reciprocal multiply, then K*cos/K*sin.
module pctva_setup
   import pctva_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   output cfg_type                  cfg
);

   localparam int CNT_W  = 6;
   localparam int BASE_W = 32;
   localparam int V_W    = 29;
   localparam int U_W    = 23;
   localparam int P_W    = 45;
   localparam int Q0_W   = 13;
   localparam int R_W    = 24;
   // 2^32 = 72000*59652 + 23296; 72000 = 64*1125
   localparam logic [BASE_W-1:0] HALF_INT  = 32'd59652;
   localparam logic [V_W-1:0]    HALF_FRAC = 29'd23296;
   localparam logic [V_W-1:0]    HALF_RND  = 29'd36000;
   localparam logic [P_W-1:0]    RECIP     = 45'd3817748;
   localparam logic [R_W-1:0]    DIV_ODD   = 24'd1125;
   localparam logic [FOV_BITS-1:0] FOV_MAX = 15'd17999;

   typedef enum logic [3:0] {
      ST_LOAD = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_ROT  = 4'b0100,
      ST_DONE = 4'b1000
   } setup_state_type;

   setup_state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [COORD_BITS-1:0] width_ff, width_in, height_ff, height_in;
   logic [FOV_BITS-1:0] hfov_ff, hfov_in, vfov_ff, vfov_in;
   logic [BASE_W-1:0] base_ff [2], base_in [2];
   logic [U_W-1:0] u_ff [2], u_in [2];
   logic [Q0_W-1:0] q0_ff [2], q0_in [2];
   logic signed [KW-1:0] rx_ff [2], rx_in [2], ry_ff [2], ry_in [2];
   logic signed [ZW-1:0] rz_ff [2], rz_in [2];

   always_comb begin
      logic [FOV_BITS-1:0] fov;
      logic [V_W-1:0] v;
      logic [P_W-1:0] p;
      logic [R_W-1:0] r;
      logic [Q0_W-1:0] q;
      logic signed [ZW-1:0] at;
      width_in  = width_ff;
      height_in = height_ff;
      hfov_in   = hfov_ff;
      vfov_in   = vfov_ff;
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      base_in = base_ff;
      u_in    = u_ff;
      q0_in   = q0_ff;
      rx_in  = rx_ff;
      ry_in  = ry_ff;
      rz_in  = rz_ff;
      fov = '0;
      v   = '0;
      p   = '0;
      r   = '0;
      q   = '0;
      at = $signed({1'b0, atan_entry(cnt_ff[4:0])});
      unique case (state_ff)
         ST_LOAD: begin
            for (int l = 0; l < 2; l++) begin
               fov = (l == AX_AZ) ? hfov_ff : vfov_ff;
               if (fov > FOV_MAX) fov = FOV_MAX;
               base_in[l] = BASE_W'(fov) * HALF_INT;
               v = V_W'(fov) * HALF_FRAC + HALF_RND;
               u_in[l] = v[V_W-1:6];
            end
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               for (int l = 0; l < 2; l++) begin
                  p = P_W'(u_ff[l]) * RECIP;
                  q0_in[l] = p[P_W-1:32];
               end
               cnt_in = cnt_ff + 1'b1;
            end else begin
               for (int l = 0; l < 2; l++) begin
                  r = R_W'(u_ff[l]) - R_W'(q0_ff[l]) * DIV_ODD;
                  q = q0_ff[l] + Q0_W'(r >= DIV_ODD);
                  rx_in[l] = KW'(1) <<< 30;
                  ry_in[l] = '0;
                  rz_in[l] = $signed({1'b0, base_ff[l] + BASE_W'(q)});
               end
               cnt_in = '0;
               state_in = ST_ROT;
            end
         end
         ST_ROT: begin
            for (int l = 0; l < 2; l++) begin
               if (!rz_ff[l][ZW-1]) begin
                  rx_in[l] = rx_ff[l] - (ry_ff[l] >>> cnt_ff);
                  ry_in[l] = ry_ff[l] + (rx_ff[l] >>> cnt_ff);
                  rz_in[l] = rz_ff[l] - at;
               end else begin
                  rx_in[l] = rx_ff[l] + (ry_ff[l] >>> cnt_ff);
                  ry_in[l] = ry_ff[l] - (rx_ff[l] >>> cnt_ff);
                  rz_in[l] = rz_ff[l] + at;
               end
            end
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
         end
         default: state_in = ST_LOAD;
      endcase
      if (csr_we) begin
         state_in = ST_LOAD;
         unique case (csr_index)
            CSR_WIDTH:  width_in  = csr_wdata[COORD_BITS-1:0];
            CSR_HEIGHT: height_in = csr_wdata[COORD_BITS-1:0];
            CSR_HFOV:   hfov_in   = csr_wdata[FOV_BITS-1:0];
            CSR_VFOV:   vfov_in   = csr_wdata[FOV_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_LOAD;
         cnt_ff    <= '0;
         width_ff  <= COORD_BITS'(1920);
         height_ff <= COORD_BITS'(1080);
         hfov_ff   <= FOV_BITS'(6000);
         vfov_ff   <= FOV_BITS'(3400);
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         hfov_ff   <= hfov_in;
         vfov_ff   <= vfov_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      u_ff    <= u_in;
      q0_ff   <= q0_in;
      rx_ff   <= rx_in;
      ry_ff   <= ry_in;
      rz_ff   <= rz_in;
   end

   always_comb begin
      cfg.size[AX_AZ] = (width_ff == '0) ? COORD_BITS'(1) : width_ff;
      cfg.size[AX_EL] = (height_ff == '0) ? COORD_BITS'(1) : height_ff;
      for (int l = 0; l < 2; l++) begin
         cfg.kcos[l] = rx_ff[l];
         cfg.ksin[l] = ry_ff[l];
      end
      cfg.busy = state_ff != ST_DONE;
   end

endmodule

// ===== design/pctva_front.sv =====
// Front end: accepts requests, forms signed pixel offsets and queues them.
module pctva_front
   import pctva_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  logic [COORD_BITS-1:0] click_x,
   input  logic [COORD_BITS-1:0] click_y,
   input  cfg_type               cfg,
   output item_type              head,
   output logic                  head_valid,
   input  logic                  take
);

   item_type mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0] cnt_ff, cnt_in;
   logic push, pop;
   item_type item;

   function automatic axis_type classify(input logic [COORD_BITS-1:0] pos,
                                         input logic [COORD_BITS-1:0] size);
      logic signed [COORD_BITS+1:0] num, negn;
      logic [COORD_BITS:0] mag;
      axis_type a;
      num  = $signed({1'b0, pos, 1'b0}) - $signed({2'b00, size});
      negn = -num;
      mag  = num[COORD_BITS+1] ? negn[COORD_BITS:0] : num[COORD_BITS:0];
      a.d   = D_W'({mag, 16'b0}) + D_W'(size >> 1);
      a.neg = num[COORD_BITS+1];
      return a;
   endfunction

   assign item.ax[AX_AZ] = classify(click_x, cfg.size[AX_AZ]);
   assign item.ax[AX_EL] = classify(click_y, cfg.size[AX_EL]);

   assign req_full   = (cnt_ff == (QPTR_W+1)'(QDEPTH)) || cfg.busy;
   assign push       = req_push && !req_full;
   assign head_valid = cnt_ff != '0;
   assign pop        = take && head_valid;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

// ===== design/pctva_back.sv =====
// Back end: pipelined divider, tangent multiply, vectoring CORDIC and millidegree scaling.
module pctva_back
   import pctva_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  cfg_type                    cfg,
   input  item_type                   head,
   input  logic                       head_valid,
   output logic                       take,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic signed [OUT_BITS-1:0] delta_az,
   output logic signed [OUT_BITS-1:0] delta_el
);

   localparam logic [MAG_W-1:0] RND = MAG_W'(64'h80000000);
   localparam logic [18:0] MDEG = 19'd360000;

   logic en;
   logic [DIV_BITS-1:0] dvld_ff, dvld_in;
   logic [D_W-1:0] rem_ff [2][DIV_BITS], rem_in [2][DIV_BITS];
   logic [DIV_BITS-1:0] quo_ff [2][DIV_BITS], quo_in [2][DIV_BITS];
   logic ovf_ff [2][DIV_BITS], ovf_in [2][DIV_BITS];
   logic neg_ff [2][DIV_BITS], neg_in [2][DIV_BITS];

   logic mvld_ff;
   logic signed [CW-1:0] t_ff [2], t_in [2];

   logic [CORDIC_STEPS-1:0] cvld_ff, cvld_in;
   logic signed [CW-1:0] cx_ff [2][CORDIC_STEPS], cx_in [2][CORDIC_STEPS];
   logic signed [CW-1:0] cy_ff [2][CORDIC_STEPS], cy_in [2][CORDIC_STEPS];
   logic signed [ZW-1:0] cz_ff [2][CORDIC_STEPS], cz_in [2][CORDIC_STEPS];

   logic svld_ff;
   logic [MAG_W-1:0] mag_ff [2], mag_in [2];
   logic sneg_ff [2], sneg_in [2];

   logic rsp_vld_ff;
   logic signed [OUT_BITS-1:0] az_ff, az_in, el_ff, el_in;

   assign en        = !rsp_vld_ff || rsp_pop;
   assign take      = en && head_valid;
   assign rsp_empty = !rsp_vld_ff;
   assign delta_az  = az_ff;
   assign delta_el  = el_ff;

   genvar l, k;
   generate
      for (k = 0; k < DIV_BITS; k++) begin : g_dvld
         if (k == 0) begin : g_first
            assign dvld_in[k] = head_valid;
         end else begin : g_next
            assign dvld_in[k] = dvld_ff[k-1];
         end
      end
      for (k = 0; k < CORDIC_STEPS; k++) begin : g_cvld
         if (k == 0) begin : g_first
            assign cvld_in[k] = mvld_ff;
         end else begin : g_next
            assign cvld_in[k] = cvld_ff[k-1];
         end
      end

      for (l = 0; l < 2; l++) begin : g_lane
         for (k = 0; k < DIV_BITS; k++) begin : g_div
            localparam int B = DIV_BITS - 1 - k;
            logic [D_W-1:0] src, dv;
            logic [DIV_BITS-1:0] qsrc;
            logic geq;
            assign dv = D_W'(cfg.size[l]) << B;
            if (k == 0) begin : g_first
               assign src        = head.ax[l].d;
               assign qsrc       = '0;
               assign ovf_in[l][k] = head.ax[l].d >= (D_W'(cfg.size[l]) << DIV_BITS);
               assign neg_in[l][k] = head.ax[l].neg;
            end else begin : g_next
               assign src        = rem_ff[l][k-1];
               assign qsrc       = quo_ff[l][k-1];
               assign ovf_in[l][k] = ovf_ff[l][k-1];
               assign neg_in[l][k] = neg_ff[l][k-1];
            end
            assign geq          = src >= dv;
            assign rem_in[l][k] = geq ? src - dv : src;
            assign quo_in[l][k] = qsrc | (DIV_BITS'(geq) << B);
         end

         logic [DIV_BITS-1:0] qs;
         logic signed [NW-1:0] nq;
         logic signed [NW+KW-1:0] prod;
         assign qs   = (ovf_ff[l][DIV_BITS-1] || quo_ff[l][DIV_BITS-1] > Q_SAT) ?
                       Q_SAT : quo_ff[l][DIV_BITS-1];
         assign nq   = neg_ff[l][DIV_BITS-1] ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
         assign prod = nq * $signed(cfg.ksin[l]);
         assign t_in[l] = CW'(prod);

         for (k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
            logic signed [CW-1:0] sx, sy;
            logic signed [ZW-1:0] sz, at;
            if (k == 0) begin : g_first
               assign sx = CW'($signed(cfg.kcos[l])) <<< 16;
               assign sy = t_ff[l];
               assign sz = '0;
            end else begin : g_next
               assign sx = cx_ff[l][k-1];
               assign sy = cy_ff[l][k-1];
               assign sz = cz_ff[l][k-1];
            end
            assign at = $signed({1'b0, atan_entry(5'(k))});
            assign cx_in[l][k] = !sy[CW-1] ? sx + (sy >>> k) : sx - (sy >>> k);
            assign cy_in[l][k] = !sy[CW-1] ? sy - (sx >>> k) : sy + (sx >>> k);
            assign cz_in[l][k] = !sy[CW-1] ? sz + at : sz - at;
         end

         logic signed [ZW-1:0] zl, zabs;
         assign zl          = cz_ff[l][CORDIC_STEPS-1];
         assign zabs        = zl[ZW-1] ? -zl : zl;
         assign sneg_in[l]  = zl[ZW-1];
         assign mag_in[l]   = MAG_W'(zabs[31:0]) * MAG_W'(MDEG);
      end
   endgenerate

   always_comb begin
      logic [MAG_W-1:0] r;
      logic [NW-1:0] q, a;
      r = (mag_ff[AX_AZ] + RND) >> 32;
      q = r[NW-1:0];
      a = sneg_ff[AX_AZ] ? -q : q;
      az_in = a[OUT_BITS-1:0];
      r = (mag_ff[AX_EL] + RND) >> 32;
      q = r[NW-1:0];
      a = sneg_ff[AX_EL] ? q : -q;
      el_in = a[OUT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dvld_ff    <= '0;
         mvld_ff    <= 1'b0;
         cvld_ff    <= '0;
         svld_ff    <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (en) begin
         dvld_ff    <= dvld_in;
         mvld_ff    <= dvld_ff[DIV_BITS-1];
         cvld_ff    <= cvld_in;
         svld_ff    <= cvld_ff[CORDIC_STEPS-1];
         rsp_vld_ff <= svld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         quo_ff  <= quo_in;
         ovf_ff  <= ovf_in;
         neg_ff  <= neg_in;
         t_ff    <= t_in;
         cx_ff   <= cx_in;
         cy_ff   <= cy_in;
         cz_ff   <= cz_in;
         mag_ff  <= mag_in;
         sneg_ff <= sneg_in;
         az_ff   <= az_in;
         el_ff   <= el_in;
      end
   end

endmodule

// ===== design/pctva_checker.sv =====
// Port-level checker for the view angle block and its bind.
`include "pixel_click_to_view_angle_macros.svh"

module pctva_checker
   import pctva_pkg::*;
(
   input logic                       clock,
   input logic                       reset,
   input logic                       req_push,
   input logic                       req_full,
   input logic [COORD_BITS-1:0]      req_click_x,
   input logic [COORD_BITS-1:0]      req_click_y,
   input logic                       rsp_empty,
   input logic                       rsp_pop,
   input logic signed [OUT_BITS-1:0] rsp_delta_az,
   input logic signed [OUT_BITS-1:0] rsp_delta_el,
   input logic                       csr_we,
   input logic [CSR_IDX_BITS-1:0]    csr_index,
   input logic [CSR_DATA_BITS-1:0]   csr_wdata
);

   `PCTVA_ASSERT_NEXT_RST(a_reset_empty, reset, rsp_empty, "result pending after reset")
   `PCTVA_ASSERT_NEXT_RST(a_reset_full, reset, req_full, "request taken during precompute")
   `PCTVA_ASSERT_NEXT(a_csr_full, csr_we, req_full, "no precompute after csr write")
   `PCTVA_ASSERT_NEXT(a_rsp_hold, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_delta_az) && $stable(rsp_delta_el), "stalled result changed")

endmodule

bind pixel_click_to_view_angle pctva_checker u_pctva_checker (.*);

// ===== tb/sv/tb_pixel_click_to_view_angle.sv =====
// Self-checking testbench: click positions in, predicted view angle offsets compared out.
`timescale 1ns / 1ps

module tb_pixel_click_to_view_angle;
   import pctva_pkg::*;

   localparam int RUN_LIMIT = 1000000;
   localparam int SETTLE    = 48;

   typedef struct {
      logic [OUT_BITS-1:0] az;
      logic [OUT_BITS-1:0] el;
   } angle_pair_type;

   localparam longint ATAN_ROM [16] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_push = 1'b0;
   logic                       req_full;
   logic [COORD_BITS-1:0]      req_click_x = '0;
   logic [COORD_BITS-1:0]      req_click_y = '0;
   logic                       rsp_empty;
   logic                       rsp_pop = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_delta_az;
   logic signed [OUT_BITS-1:0] rsp_delta_el;
   logic                       csr_we = 1'b0;
   logic [CSR_IDX_BITS-1:0]    csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_wdata = '0;

   logic [COORD_BITS-1:0] frame_w, frame_h;
   logic [FOV_BITS-1:0]   fov_h, fov_v;

   angle_pair_type pending_angles[$];
   int        send_idle_pct = 0;
   int        pop_stall_pct = 0;
   int        fail_count = 0;
   int        click_count = 0;
   int        angle_count = 0;
   int        cycle_count = 0;

   pixel_click_to_view_angle u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("pixel_click_to_view_angle regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= pop_stall_pct);
   end

   always @(posedge clock) begin
      angle_pair_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (pending_angles.size() == 0) begin
            $error("unexpected result az %0d el %0d", rsp_delta_az, rsp_delta_el);
            fail_count++;
         end else begin
            e = pending_angles.pop_front();
            angle_count++;
            if (rsp_delta_az !== e.az) begin
               $error("delta_az expected %0d actual %0d", $signed(e.az), rsp_delta_az);
               fail_count++;
            end
            if (rsp_delta_el !== e.el) begin
               $error("delta_el expected %0d actual %0d", $signed(e.el), rsp_delta_el);
               fail_count++;
            end
         end
      end
   end

   function automatic longint axis_mdeg(input logic [COORD_BITS-1:0] pos,
                                        input logic [COORD_BITS-1:0] size_in,
                                        input logic [FOV_BITS-1:0] fov_in);
      longint num, n, x, y, z, t, dx, dy;
      longint unsigned mag, q, half, size, fov;
      size = (size_in == 0) ? 1 : size_in;
      fov  = (fov_in > 17999) ? 17999 : fov_in;
      num  = 2 * longint'(pos) - longint'(size);
      mag  = (num < 0 ? -num : num) << 16;
      q    = (mag + size / 2) / size;
      if (q > 131072) q = 131072;
      n    = (num < 0) ? -longint'(q) : longint'(q);
      half = ((fov << 32) + 36000) / 72000;
      x = longint'(1) << 30;
      y = 0;
      z = longint'(half);
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ATAN_ROM[i];
         end else begin
            x += dx; y -= dy; z += ATAN_ROM[i];
         end
      end
      t = n * y;
      x = x * 65536;
      y = t;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_ROM[i];
         end else begin
            x -= dx; y += dy; z -= ATAN_ROM[i];
         end
      end
      mag = (z < 0 ? -z : z) * 360000;
      q   = (mag + (64'd1 << 31)) >> 32;
      return (z < 0) ? -longint'(q) : longint'(q);
   endfunction

   // all tasks start and end at a rising edge
   task automatic send_click(input int cx, input int cy);
      angle_pair_type e;
      longint az, el;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_click_x <= COORD_BITS'(cx);
      req_click_y <= COORD_BITS'(cy);
      @(posedge clock);
      while (req_full) @(posedge clock);
      az   = axis_mdeg(COORD_BITS'(cx), frame_w, fov_h);
      el   = -axis_mdeg(COORD_BITS'(cy), frame_h, fov_v);
      e.az = az[OUT_BITS-1:0];
      e.el = el[OUT_BITS-1:0];
      pending_angles.push_back(e);
      click_count++;
   endtask

   task automatic drain_angles();
      req_push <= 1'b0;
      @(posedge clock);
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx, input int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(val);
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WIDTH:  frame_w = val[COORD_BITS-1:0];
         CSR_HEIGHT: frame_h = val[COORD_BITS-1:0];
         CSR_HFOV:   fov_h   = val[FOV_BITS-1:0];
         CSR_VFOV:   fov_v   = val[FOV_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_view(input int w, input int h, input int fh, input int fv);
      drain_angles();
      write_reg(CSR_WIDTH, w);
      write_reg(CSR_HEIGHT, h);
      write_reg(CSR_HFOV, fh);
      write_reg(CSR_VFOV, fv);
   endtask

   task automatic test_defaults_and_edges();
      send_click(960, 540);
      send_click(0, 0);
      send_click(1920, 1080);
      send_click(4096, 4096);
      send_click(8191, 8191);
      send_click(1919, 1);
   endtask

   task automatic test_extreme_views();
      set_view(4096, 4096, 17999, 17999);
      send_click(0, 4096);
      send_click(4096, 0);
      send_click(2048, 2048);
      set_view(0, 0, 0, 0);
      send_click(0, 1);
      send_click(8191, 2);
      set_view(1, 1, 1, 32767);
      send_click(0, 1);
      send_click(1, 0);
      set_view(1280, 720, 32767, 18000);
      send_click(100, 700);
      send_click(640, 360);
   endtask

   task automatic test_ignored_index();
      drain_angles();
      for (int i = 4; i < 8; i++) write_reg(CSR_IDX_BITS'(i), 32'h7FFF);
      send_click(300, 200);
      send_click(1279, 719);
   endtask

   task automatic test_random_clicks();
      int views [6][4] = '{
         '{1920, 1080, 6000, 3400}, '{4096, 4096, 17999, 17999}, '{1, 1, 1, 1},
         '{0, 0, 0, 0}, '{640, 480, 9000, 32767}, '{-1, -1, -1, -1}};
      int idle [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{24, 24}};
      int w, h, cx, cy;
      for (int v = 0; v < 6; v++) begin
         if (views[v][0] < 0)
            set_view($urandom_range(32767), $urandom_range(32767),
                     $urandom_range(32767), $urandom_range(32767));
         else
            set_view(views[v][0], views[v][1], views[v][2], views[v][3]);
         w = (frame_w == 0) ? 1 : frame_w;
         h = (frame_h == 0) ? 1 : frame_h;
         for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle[p][0];
            pop_stall_pct = idle[p][1];
            for (int k = 0; k < 80; k++) begin
               if ($urandom_range(9) < 8) begin
                  cx = $urandom_range(w);
                  cy = $urandom_range(h);
               end else begin
                  cx = $urandom_range(8191);
                  cy = $urandom_range(8191);
               end
               send_click(cx, cy);
               if (v == 2 && p == 1 && k == 40) drain_angles();
            end
         end
      end
      send_idle_pct = 0;
      pop_stall_pct = 0;
   endtask

   initial begin
      frame_w = 1920;
      frame_h = 1080;
      fov_h   = 6000;
      fov_v   = 3400;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults_and_edges();
      test_extreme_views();
      test_ignored_index();
      test_random_clicks();
      drain_angles();
      $display("sent %0d clicks over extreme, zero and random views under four stall mixes",
               click_count);
      $display("checked %0d angle results, %0d mismatches", angle_count, fail_count);
      if (fail_count == 0 && pending_angles.size() == 0)
         $display("pixel_click_to_view_angle regression: pass");
      else
         $display("pixel_click_to_view_angle regression: fail");
      $finish;
   end

endmodule
